@@ src/glyph_point_in_polygon_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the glyph point-in-polygon block
// Each macro samples on clk and is disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef GLYPH_POINT_IN_POLYGON_TOP_MACROS_SVH
`define GLYPH_POINT_IN_POLYGON_TOP_MACROS_SVH

// cond holds at every clock edge
`define GPIP_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("gpip: invariant violated");

// cons holds in the same cycle as ante
`define GPIP_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gpip: implication violated");

`endif

@@ src/gpip_pkg.sv @@
// ----------------------------------------------------------------------------
// gpip_pkg
// Shared types and constants of the glyph point-in-polygon block.
// ----------------------------------------------------------------------------
package gpip_pkg;

	// input word opcodes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// configuration register indexes
	localparam int          REG_INDEX_W      = 3;
	localparam logic [2:0]  REG_EXTENT_LEFT   = 3'd0;
	localparam logic [2:0]  REG_EXTENT_RIGHT  = 3'd1;
	localparam logic [2:0]  REG_EXTENT_BOTTOM = 3'd2;
	localparam logic [2:0]  REG_EXTENT_TOP    = 3'd3;
	localparam logic [2:0]  REG_VERTEX_COUNT  = 3'd4;
	localparam int          REG_DATA_W       = 9;

	localparam int COORD_W = 8;
	localparam int POINT_W = 17;
	localparam int COUNT_W = 9;

	// command queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QLEVEL_W    = 2;

	typedef struct packed {
		logic [7:0] extent_left;
		logic [7:0] extent_right;
		logic [7:0] extent_bottom;
		logic [7:0] extent_top;
		logic [8:0] vertex_count;
	} cfg_t;

	typedef struct packed {
		logic        is_query;
		logic        skip;       // query answered 0 without walking the outline
		logic [7:0]  vidx;
		logic [7:0]  vx;
		logic [7:0]  vy;
		logic [16:0] px;
		logic [16:0] py;
		logic [7:0]  xr;         // rounded point, valid when the extent test passed
		logic [7:0]  yr;
	} cmd_t;

	typedef struct packed {
		logic [QLEVEL_W-1:0] level;
		logic                full;
		logic                empty;
	} qstat_t;

	typedef struct packed {
		logic idle;
		logic done;
	} bstat_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_READ,
		BK_DRAIN,
		BK_DONE
	} bk_state_t;

endpackage

@@ src/glyph_point_in_polygon_top.sv @@
// ----------------------------------------------------------------------------
// glyph_point_in_polygon_top
// Crossing-number point-in-outline test for one font glyph.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one word per item. op selects a
//   vertex write (vertex_index, vertex_x, vertex_y) or a point query
//   (point_x, point_y, fixed point). Output channel (out_valid/out_ready)
//   returns one inside_res word per query; vertex writes return nothing.
//   Registers (extent box, vertex_count) are set through wr_en/wr_index/
//   wr_data while no query is in flight.
//   A two-entry queue sits between the input side and the edge walker, so
//   input words keep being taken while a query walks or a result waits.
//   A vertex write is stored as it leaves the queue.
//   A query that fails the extent test, or finds no vertices, skips the
//   edge walk; otherwise the walk reads the closing vertex and then n
//   vertices, n the vertex count clamped to MAX_VERTICES, one vertex per
//   cycle from the single-port vertex store.
//   Reset clears the registers, the queue and the output valid flag; vertex
//   entries hold garbage until written. While out_ready stays low the
//   result holds, the walker stalls, and in_ready drops once the queue fills.
// ----------------------------------------------------------------------------
`include "glyph_point_in_polygon_top_macros.svh"

module glyph_point_in_polygon_top #(
	parameter int MAX_VERTICES    = 256,
	parameter int POINT_FRAC_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic [7:0]  vertex_index,
	input  logic [7:0]  vertex_x,
	input  logic [7:0]  vertex_y,
	input  logic [16:0] point_x,
	input  logic [16:0] point_y,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        inside_res,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [8:0]  wr_data
);

	gpip_pkg::cfg_t   cfg_q;
	gpip_pkg::cmd_t   push_cmd;
	gpip_pkg::cmd_t   head_cmd;
	gpip_pkg::qstat_t qstat;
	gpip_pkg::bstat_t bstat;
	logic             push;
	logic             cmd_valid;
	logic             cmd_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				gpip_pkg::REG_EXTENT_LEFT:   cfg_q.extent_left   <= wr_data[7:0];
				gpip_pkg::REG_EXTENT_RIGHT:  cfg_q.extent_right  <= wr_data[7:0];
				gpip_pkg::REG_EXTENT_BOTTOM: cfg_q.extent_bottom <= wr_data[7:0];
				gpip_pkg::REG_EXTENT_TOP:    cfg_q.extent_top    <= wr_data[7:0];
				gpip_pkg::REG_VERTEX_COUNT:  cfg_q.vertex_count  <= wr_data;
				default: begin
				end
			endcase
		end
	end

	gpip_front #(
		.MAX_VERTICES    (MAX_VERTICES),
		.POINT_FRAC_BITS (POINT_FRAC_BITS)
	) u_front (
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.vertex_index (vertex_index),
		.vertex_x     (vertex_x),
		.vertex_y     (vertex_y),
		.point_x      (point_x),
		.point_y      (point_y),
		.cfg          (cfg_q),
		.qstat        (qstat),
		.push         (push),
		.cmd          (push_cmd)
	);

	gpip_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.cmd_in    (push_cmd),
		.pop       (cmd_pop),
		.cmd_valid (cmd_valid),
		.cmd_out   (head_cmd),
		.qstat     (qstat)
	);

	gpip_back #(
		.MAX_VERTICES    (MAX_VERTICES),
		.POINT_FRAC_BITS (POINT_FRAC_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd          (head_cmd),
		.cmd_pop      (cmd_pop),
		.vertex_count (cfg_q.vertex_count),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.inside_res   (inside_res),
		.bstat        (bstat)
	);

	`GPIP_ASSERT_ALWAYS(a_queue_level, qstat.full == (qstat.level == 2'(gpip_pkg::QUEUE_DEPTH)))
	`GPIP_ASSERT_IMPLY(a_pop_when_idle, cmd_pop, bstat.idle && !qstat.empty)
	`GPIP_ASSERT_IMPLY(a_result_from_done, out_valid && !$past(out_valid), $past(bstat.done))

endmodule

@@ src/gpip_front.sv @@
// ----------------------------------------------------------------------------
// gpip_front
// Accepts input words, rounds the query point and applies the extent test.
// ----------------------------------------------------------------------------
module gpip_front #(
	parameter int MAX_VERTICES    = 256,
	parameter int POINT_FRAC_BITS = 8
) (
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 op,
	input  logic [7:0]           vertex_index,
	input  logic [7:0]           vertex_x,
	input  logic [7:0]           vertex_y,
	input  logic [16:0]          point_x,
	input  logic [16:0]          point_y,
	input  gpip_pkg::cfg_t       cfg,
	input  gpip_pkg::qstat_t     qstat,
	output logic                 push,
	output gpip_pkg::cmd_t       cmd
);

	localparam logic [17:0] HALF = 18'((1 << POINT_FRAC_BITS) >> 1);

	logic        accept;
	logic        drop;
	logic [17:0] xr_full;
	logic [17:0] yr_full;
	logic        outside;

	assign in_ready = !qstat.full;
	assign accept   = in_valid && in_ready;

	// drop writes beyond the store
	assign drop = (op == gpip_pkg::OP_WRITE) && (32'(vertex_index) >= 32'(MAX_VERTICES));
	assign push = accept && !drop;

	assign xr_full = ({1'b0, point_x} + HALF) >> POINT_FRAC_BITS;
	assign yr_full = ({1'b0, point_y} + HALF) >> POINT_FRAC_BITS;

	assign outside = ({10'd0, cfg.extent_left} > xr_full) ||
		({10'd0, cfg.extent_right} <= xr_full) ||
		({10'd0, cfg.extent_bottom} > yr_full) ||
		({10'd0, cfg.extent_top} <= yr_full);

	always_comb begin
		cmd.is_query = (op == gpip_pkg::OP_QUERY);
		cmd.skip     = outside || (cfg.vertex_count == '0);
		cmd.vidx     = vertex_index;
		cmd.vx       = vertex_x;
		cmd.vy       = vertex_y;
		cmd.px       = point_x;
		cmd.py       = point_y;
		cmd.xr       = xr_full[7:0];
		cmd.yr       = yr_full[7:0];
	end

endmodule

@@ src/gpip_queue.sv @@
// ----------------------------------------------------------------------------
// gpip_queue
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module gpip_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  gpip_pkg::cmd_t   cmd_in,
	input  logic             pop,
	output logic             cmd_valid,
	output gpip_pkg::cmd_t   cmd_out,
	output gpip_pkg::qstat_t qstat
);

	localparam int PTR_W = gpip_pkg::QPTR_W;
	localparam int LVL_W = gpip_pkg::QLEVEL_W;
	localparam int DEPTH = gpip_pkg::QUEUE_DEPTH;

	gpip_pkg::cmd_t   slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [LVL_W-1:0] level_q;

	assign cmd_valid   = (level_q != '0);
	assign cmd_out     = slot_q[rd_ptr_q];
	assign qstat.level = level_q;
	assign qstat.full  = (level_q == LVL_W'(DEPTH));
	assign qstat.empty = (level_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				level_q <= level_q + LVL_W'(1);
			end else if (pop && !push) begin
				level_q <= level_q - LVL_W'(1);
			end
		end
	end

endmodule

@@ src/gpip_back.sv @@
// ----------------------------------------------------------------------------
// gpip_back
// Owns the vertex store, walks the closed edge list one edge per cycle and
// holds the crossing parity in the output register.
// ----------------------------------------------------------------------------
module gpip_back #(
	parameter int MAX_VERTICES    = 256,
	parameter int POINT_FRAC_BITS = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	input  gpip_pkg::cmd_t   cmd,
	output logic             cmd_pop,
	input  logic [8:0]       vertex_count,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             inside_res,
	output gpip_pkg::bstat_t bstat
);

	localparam int AW    = $clog2(MAX_VERTICES);
	localparam int NB    = $clog2(MAX_VERTICES + 1);
	localparam int CNT_W = (NB > 9) ? NB : 9;
	localparam int SW    = 8 + POINT_FRAC_BITS;
	localparam int DW    = ((SW > 17) ? SW : 17) + 1;
	localparam int PW    = 2 * DW;
	localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_VERTICES);

	gpip_pkg::bk_state_t st_q, st_d;

	logic [15:0]      vstore_q [MAX_VERTICES];
	logic [15:0]      rdata_s1;
	logic             rv_s1;
	logic             first_s1;
	logic [15:0]      prev_q;

	logic [CNT_W-1:0] n_eff;
	logic [CNT_W-1:0] rd_cnt_q;
	logic [AW-1:0]    rd_addr;
	logic             rd_en;
	logic             wr_en;
	logic             start;
	logic             load_out;
	logic             out_free;

	logic [7:0]       xr_q, yr_q;
	logic [16:0]      fx_q, fy_q;
	logic             parity_q;
	logic             out_valid_q;
	logic             inside_q;

	// edge evaluation
	logic [7:0]           ax, ay, bx, by;
	logic                 straddle, a_right, b_right;
	logic [DW-1:0]        sax, say, sbx, sby, fx_ext, fy_ext;
	logic                 ev_s2, sure_s2, test_s2, up_s2;
	logic signed [DW-1:0] d_ay_fy_s2, d_bx_fx_s2, d_ax_fx_s2, d_by_fy_s2;
	logic                 ev_s3, sure_s3, test_s3, up_s3;
	logic signed [PW-1:0] lhs_s3, rhs_s3;
	logic                 crossed;

	assign n_eff    = (CNT_W'(vertex_count) > MAX_N) ? MAX_N : CNT_W'(vertex_count);
	assign out_free = !out_valid_q || out_ready;

	// first read fetches the closing vertex, then vertices 0 .. n-1
	assign rd_addr = (rd_cnt_q == '0) ? AW'(n_eff - CNT_W'(1)) : AW'(rd_cnt_q - CNT_W'(1));

	always_comb begin
		st_d     = st_q;
		cmd_pop  = 1'b0;
		wr_en    = 1'b0;
		rd_en    = 1'b0;
		start    = 1'b0;
		load_out = 1'b0;
		case (st_q)
			gpip_pkg::BK_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					if (!cmd.is_query) begin
						wr_en = 1'b1;
					end else begin
						start = 1'b1;
						st_d  = cmd.skip ? gpip_pkg::BK_DONE : gpip_pkg::BK_READ;
					end
				end
			end
			gpip_pkg::BK_READ: begin
				rd_en = 1'b1;
				if (rd_cnt_q == n_eff) begin
					st_d = gpip_pkg::BK_DRAIN;
				end
			end
			gpip_pkg::BK_DRAIN: begin
				if (!rv_s1 && !ev_s2 && !ev_s3) begin
					st_d = gpip_pkg::BK_DONE;
				end
			end
			gpip_pkg::BK_DONE: begin
				if (out_free) begin
					load_out = 1'b1;
					st_d     = gpip_pkg::BK_IDLE;
				end
			end
			default: begin
				st_d = gpip_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= gpip_pkg::BK_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// vertex store: x in the high byte, y in the low byte
	always_ff @(posedge clk) begin
		if (wr_en) begin
			vstore_q[AW'(cmd.vidx)] <= {cmd.vx, cmd.vy};
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_s1 <= vstore_q[rd_addr];
		end
	end

	assign ax = prev_q[15:8];
	assign ay = prev_q[7:0];
	assign bx = rdata_s1[15:8];
	assign by = rdata_s1[7:0];

	assign straddle = (ay > yr_q) != (by > yr_q);
	assign a_right  = ax > xr_q;
	assign b_right  = bx > xr_q;

	assign sax    = DW'(ax) << POINT_FRAC_BITS;
	assign say    = DW'(ay) << POINT_FRAC_BITS;
	assign sbx    = DW'(bx) << POINT_FRAC_BITS;
	assign sby    = DW'(by) << POINT_FRAC_BITS;
	assign fx_ext = DW'(fx_q);
	assign fy_ext = DW'(fy_q);

	assign crossed = sure_s3 || (test_s3 && (up_s3 != (lhs_s3 > rhs_s3)));

	always_ff @(posedge clk) begin
		if (start) begin
			xr_q <= cmd.xr;
			yr_q <= cmd.yr;
			fx_q <= cmd.px;
			fy_q <= cmd.py;
		end
		if (rv_s1) begin
			prev_q <= rdata_s1;
		end
		sure_s2    <= straddle && a_right && b_right;
		test_s2    <= straddle && (a_right != b_right);
		up_s2      <= by > ay;
		d_ay_fy_s2 <= $signed(say) - $signed(fy_ext);
		d_bx_fx_s2 <= $signed(sbx) - $signed(fx_ext);
		d_ax_fx_s2 <= $signed(sax) - $signed(fx_ext);
		d_by_fy_s2 <= $signed(sby) - $signed(fy_ext);
		sure_s3    <= sure_s2;
		test_s3    <= test_s2;
		up_s3      <= up_s2;
		lhs_s3     <= d_ay_fy_s2 * d_bx_fx_s2;
		rhs_s3     <= d_ax_fx_s2 * d_by_fy_s2;
		if (load_out) begin
			inside_q <= parity_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q    <= '0;
			rv_s1       <= 1'b0;
			first_s1    <= 1'b0;
			ev_s2       <= 1'b0;
			ev_s3       <= 1'b0;
			parity_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (start) begin
				rd_cnt_q <= '0;
			end else if (rd_en) begin
				rd_cnt_q <= rd_cnt_q + CNT_W'(1);
			end
			rv_s1    <= rd_en;
			first_s1 <= rd_en && (rd_cnt_q == '0);
			ev_s2    <= rv_s1 && !first_s1;
			ev_s3    <= ev_s2;
			if (start) begin
				parity_q <= 1'b0;
			end else if (ev_s3) begin
				parity_q <= parity_q ^ crossed;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign inside_res  = inside_q;
	assign bstat.idle  = (st_q == gpip_pkg::BK_IDLE);
	assign bstat.done  = (st_q == gpip_pkg::BK_DONE);

endmodule

@@ tb/sv/glyph_point_in_polygon_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// glyph_point_in_polygon_top_tb
// Self-checking bench for the glyph point-in-outline block. A short directed
// table covers reset values, extremes and degenerate outlines. Random phases
// follow, each loading an outline and querying points around it. Every
// inside_res word is checked against a pinned value or a bench predictor.
// ----------------------------------------------------------------------------
module glyph_point_in_polygon_top_tb;
	import gpip_pkg::*;

	localparam int CLK_HALF      = 10;
	localparam int RESET_CYCLES  = 12;
	localparam int STORE_DEPTH   = 256;
	localparam int FRAC          = 8;
	localparam int HALF_UNIT     = 1 << (FRAC - 1);
	localparam int POINT_MAX     = 'h1FFFF;
	localparam int RANDOM_WORDS  = 1900;
	localparam int SETTLE_CYCLES = 16;
	localparam int DRAIN_CYCLES  = STORE_DEPTH + 16;
	localparam int CYCLE_LIMIT   = 3_000_000;
	localparam int DIRECTED_ROWS = 25;

	typedef struct {
		bit          cfg_row;
		cfg_t        regs;
		logic        op;
		logic [7:0]  idx;
		logic [7:0]  vx;
		logic [7:0]  vy;
		logic [16:0] px;
		logic [16:0] py;
		bit          pinned;
		bit          pinned_val;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        op;
	logic [7:0]  vertex_index;
	logic [7:0]  vertex_x;
	logic [7:0]  vertex_y;
	logic [16:0] point_x;
	logic [16:0] point_y;
	logic        out_valid;
	logic        out_ready;
	logic        inside_res;
	logic        wr_en;
	logic [REG_INDEX_W-1:0] wr_index;
	logic [REG_DATA_W-1:0]  wr_data;

	// bench copy of the block state
	cfg_t       box = '0;
	logic [7:0] outline_x [STORE_DEPTH] = '{default: '0};
	logic [7:0] outline_y [STORE_DEPTH] = '{default: '0};
	bit         loaded    [STORE_DEPTH] = '{default: 1'b0};
	bit         pending_inside [$];

	int   mismatches = 0;
	int   words_sent = 0;
	int   cycles     = 0;
	logic want;

	row_t directed_plan [DIRECTED_ROWS] = '{
		// reset values: empty extent
		'{1'b0, '0, OP_QUERY, 8'd0, 8'd0, 8'd0, 17'h00000, 17'h00000, 1'b1, 1'b0},
		'{1'b0, '0, OP_QUERY, 8'd0, 8'd0, 8'd0, 17'h1FFFF, 17'h1FFFF, 1'b1, 1'b0},
		'{1'b1, '{8'd0, 8'd255, 8'd0, 8'd255, 9'd0}, OP_WRITE,
			8'd0, 8'd0, 8'd0, 17'h0, 17'h0, 1'b0, 1'b0},
		// no vertices in use
		'{1'b0, '0, OP_QUERY, 8'd0, 8'd0, 8'd0, 17'h06400, 17'h06400, 1'b1, 1'b0},
		// square outline plus the top store entry
		'{1'b0, '0, OP_WRITE, 8'd0, 8'd10, 8'd10, 17'h1FFFF, 17'h00000, 1'b0, 1'b0},
		'{1'b0, '0, OP_WRITE, 8'd1, 8'd200, 8'd10, 17'h0, 17'h0, 1'b0, 1'b0},
		'{1'b0, '0, OP_WRITE, 8'd2, 8'd200, 8'd200, 17'h0, 17'h0, 1'b0, 1'b0},
		'{1'b0, '0, OP_WRITE, 8'd3, 8'd10, 8'd200, 17'h0, 17'h0, 1'b0, 1'b0},
		'{1'b0, '0, OP_WRITE, 8'd255, 8'd255, 8'd255, 17'h0, 17'h1FFFF, 1'b0, 1'b0},
		'{1'b1, '{8'd0, 8'd255, 8'd0, 8'd255, 9'd4}, OP_WRITE,
			8'd0, 8'd0, 8'd0, 17'h0, 17'h0, 1'b0, 1'b0},
		'{1'b0, '0, OP_QUERY, 8'd0, 8'd0, 8'd0, 17'h06400, 17'h06400, 1'b0, 1'b0},
		'{1'b0, '0, OP_QUERY, 8'd0, 8'd0, 8'd0, 17'h00500, 17'h06400, 1'b0, 1'b0},
		// half a unit rounds up onto the right edge
		'{1'b0, '0, OP_QUERY, 8'd0, 8'd0, 8'd0, 17'h0C780, 17'h06440, 1'b0, 1'b0},
		'{1'b0, '0, OP_QUERY, 8'd0, 8'd0, 8'd0, 17'h00A00, 17'h00A00, 1'b0, 1'b0},
		// point beyond the 8-bit grid
		'{1'b0, '0, OP_QUERY, 8'd0, 8'd0, 8'd0, 17'h10000, 17'h06400, 1'b1, 1'b0},
		'{1'b0, '0, OP_QUERY, 8'd0, 8'd0, 8'd0, 17'h1FFFF, 17'h00000, 1'b1, 1'b0},
		// slanted triangle: exercises the cross-product test
		'{1'b0, '0, OP_WRITE, 8'd0, 8'd0, 8'd0, 17'h0, 17'h0, 1'b0, 1'b0},
		'{1'b0, '0, OP_WRITE, 8'd1, 8'd255, 8'd128, 17'h0, 17'h0, 1'b0, 1'b0},
		'{1'b0, '0, OP_WRITE, 8'd2, 8'd0, 8'd255, 17'h0, 17'h0, 1'b0, 1'b0},
		'{1'b1, '{8'd0, 8'd255, 8'd0, 8'd255, 9'd3}, OP_WRITE,
			8'd0, 8'd0, 8'd0, 17'h0, 17'h0, 1'b0, 1'b0},
		'{1'b0, '0, OP_QUERY, 8'd0, 8'd0, 8'd0, 17'h0644D, 17'h03CB3, 1'b0, 1'b0},
		'{1'b0, '0, OP_QUERY, 8'd0, 8'd0, 8'd0, 17'h07F80, 17'h04000, 1'b0, 1'b0},
		'{1'b0, '0, OP_QUERY, 8'd0, 8'd0, 8'd0, 17'h0FEE6, 17'h07FE6, 1'b0, 1'b0},
		// missing glyph
		'{1'b1, '{8'd100, 8'd100, 8'd0, 8'd255, 9'd3}, OP_WRITE,
			8'd0, 8'd0, 8'd0, 17'h0, 17'h0, 1'b0, 1'b0},
		'{1'b0, '0, OP_QUERY, 8'd0, 8'd0, 8'd0, 17'h06400, 17'h06400, 1'b1, 1'b0}
	};

	glyph_point_in_polygon_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.vertex_index (vertex_index),
		.vertex_x     (vertex_x),
		.vertex_y     (vertex_y),
		.point_x      (point_x),
		.point_y      (point_y),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.inside_res   (inside_res),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// crossing parity along +x from the point, against the bench outline
	function automatic bit point_inside(input logic [16:0] px, input logic [16:0] py);
		int     xr, yr, n, prev, k, crossings;
		longint ax, ay, bx, by, fx, fy, lhs, rhs;
		bit     up, gt;
		xr = (int'(px) + HALF_UNIT) >> FRAC;
		yr = (int'(py) + HALF_UNIT) >> FRAC;
		fx = px;
		fy = py;
		if (int'(box.extent_left) > xr || int'(box.extent_right) <= xr ||
			int'(box.extent_bottom) > yr || int'(box.extent_top) <= yr)
			return 1'b0;
		n = box.vertex_count;
		if (n > STORE_DEPTH)
			n = STORE_DEPTH;
		if (n == 0)
			return 1'b0;
		crossings = 0;
		prev = n - 1;
		for (k = 0; k < n; k++) begin
			ax = outline_x[prev];
			ay = outline_y[prev];
			bx = outline_x[k];
			by = outline_y[k];
			if ((ay > yr) != (by > yr)) begin
				if (ax > xr && bx > xr) begin
					crossings++;
				end else if (ax > xr || bx > xr) begin
					// side of the edge, exact at the point's full precision
					lhs = ((ay << FRAC) - fy) * ((bx << FRAC) - fx);
					rhs = ((ax << FRAC) - fx) * ((by << FRAC) - fy);
					gt = lhs > rhs;
					up = by > ay;
					if (up != gt)
						crossings++;
				end
			end
			prev = k;
		end
		return crossings[0];
	endfunction

	// mostly back to back, some short gaps, a few long ones
	function automatic int pick_gap(input bit burst);
		int r;
		r = $urandom_range(0, 15);
		if (burst || r < 8)
			return 0;
		if (r < 14)
			return $urandom_range(1, 3);
		return $urandom_range(8, 60);
	endfunction

	// fixed-point coordinate around a span of glyph units
	function automatic logic [16:0] pick_fixed(input int lo_unit, input int hi_unit);
		int lo, hi;
		lo = (lo_unit << FRAC) - 256;
		hi = (hi_unit << FRAC) + 256;
		if (lo < 0)
			lo = 0;
		if (hi > POINT_MAX)
			hi = POINT_MAX;
		return 17'($urandom_range(hi, lo));
	endfunction

	task automatic send_word(input logic o, input logic [7:0] idx, input logic [7:0] vx,
		input logic [7:0] vy, input logic [16:0] px, input logic [16:0] py, input int gap,
		input bit pinned, input bit pinned_val);
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid     <= 1'b1;
		op           <= o;
		vertex_index <= idx;
		vertex_x     <= vx;
		vertex_y     <= vy;
		point_x      <= px;
		point_y      <= py;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		words_sent++;
		if (o == OP_WRITE) begin
			outline_x[idx] = vx;
			outline_y[idx] = vy;
			loaded[idx]    = 1'b1;
		end else begin
			pending_inside.push_back(pinned ? pinned_val : point_inside(px, py));
		end
	endtask

	// drop valid, drain all queries, then let trailing vertex writes retire
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_inside.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic put_reg(input logic [REG_INDEX_W-1:0] idx, input logic [REG_DATA_W-1:0] data);
		@(negedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(posedge clk);
	endtask

	task automatic write_regs(input cfg_t r);
		put_reg(REG_EXTENT_LEFT,   {1'b0, r.extent_left});
		put_reg(REG_EXTENT_RIGHT,  {1'b0, r.extent_right});
		put_reg(REG_EXTENT_BOTTOM, {1'b0, r.extent_bottom});
		put_reg(REG_EXTENT_TOP,    {1'b0, r.extent_top});
		put_reg(REG_VERTEX_COUNT,  r.vertex_count);
		@(negedge clk);
		wr_en <= 1'b0;
		box = r;
	endtask

	// receiver: free-running stretches alternate with random stalls
	initial begin
		int stall_left, mode_left;
		bit free_mode;
		stall_left = 0;
		mode_left  = 0;
		free_mode  = 1'b0;
		out_ready  = 1'b0;
		forever begin
			@(negedge clk);
			if (mode_left == 0) begin
				free_mode = ($urandom_range(0, 2) == 0);
				mode_left = $urandom_range(50, 400);
			end
			mode_left--;
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (!free_mode && $urandom_range(0, 3) == 0) begin
				stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 60) :
					$urandom_range(0, 2);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_inside.size() == 0) begin
				$display("%0t: inside_res word with no query pending, expected none, got %0b",
					$time, inside_res);
				mismatches++;
			end else begin
				want = pending_inside.pop_front();
				if (inside_res !== want) begin
					$display("%0t: inside_res mismatch, expected %0b, got %0b",
						$time, want, inside_res);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL glyph_point_in_polygon_top");
			$finish;
		end
	end

	initial begin
		int          i, j, kind, nq, n_eff, cnt, sel, v, w, lft, rgt, bot, tp, big_phases;
		bit          burst, reuse;
		cfg_t        regs;
		logic [7:0]  cx, cy;
		logic [16:0] qx, qy;

		arst_n       = 1'b0;
		in_valid     = 1'b0;
		op           = OP_WRITE;
		vertex_index = '0;
		vertex_x     = '0;
		vertex_y     = '0;
		point_x      = '0;
		point_y      = '0;
		wr_en        = 1'b0;
		wr_index     = REG_EXTENT_LEFT;
		wr_data      = '0;
		big_phases   = 0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		for (i = 0; i < DIRECTED_ROWS; i++) begin
			if (directed_plan[i].cfg_row) begin
				wait_idle();
				write_regs(directed_plan[i].regs);
			end else begin
				send_word(directed_plan[i].op, directed_plan[i].idx, directed_plan[i].vx,
					directed_plan[i].vy, directed_plan[i].px, directed_plan[i].py,
					pick_gap(1'b0), directed_plan[i].pinned, directed_plan[i].pinned_val);
			end
		end

		words_sent = 0;
		while (words_sent < RANDOM_WORDS) begin
			wait_idle();
			kind  = $urandom_range(0, 19);
			burst = ($urandom_range(0, 3) == 0);

			lft = $urandom_range(0, 200);
			rgt = $urandom_range(lft + 1, 255);
			bot = $urandom_range(0, 200);
			tp  = $urandom_range(bot + 1, 255);
			if ($urandom_range(0, 3) == 0) begin
				lft = 0;
				rgt = 255;
				bot = 0;
				tp  = 255;
			end
			if (kind == 0) begin
				// missing glyph: collapse the box on one axis
				if ($urandom_range(0, 3) == 0) begin
					lft = 255;
					rgt = 255;
				end else if ($urandom_range(0, 1) == 1) begin
					rgt = $urandom_range(0, lft);
				end else begin
					tp = $urandom_range(0, bot);
				end
			end

			if (kind == 0) begin
				cnt = $urandom_range(0, 511);
			end else if (kind == 1) begin
				cnt = 0;
			end else if (kind == 2 && big_phases < 3) begin
				big_phases++;
				case ($urandom_range(0, 2))
					0: cnt = STORE_DEPTH;
					1: cnt = 511;
					default: cnt = $urandom_range(STORE_DEPTH + 1, 510);
				endcase
			end else if (kind == 3) begin
				cnt = $urandom_range(1, 2);
			end else begin
				cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 64) :
					$urandom_range(3, 24);
			end
			n_eff = (cnt > STORE_DEPTH) ? STORE_DEPTH : cnt;

			regs.extent_left   = 8'(lft);
			regs.extent_right  = 8'(rgt);
			regs.extent_bottom = 8'(bot);
			regs.extent_top    = 8'(tp);
			regs.vertex_count  = 9'(cnt);
			write_regs(regs);

			// keep the previous outline now and then, if it covers every vertex in use
			reuse = ($urandom_range(0, 3) == 0);
			for (j = 0; j < n_eff; j++)
				if (!loaded[j])
					reuse = 1'b0;
			if (kind != 0 && n_eff > 0 && !reuse) begin
				for (j = 0; j < n_eff; j++) begin
					if ($urandom_range(0, 5) == 0) begin
						cx = 8'($urandom_range(0, 255));
						cy = 8'($urandom_range(0, 255));
					end else begin
						cx = 8'($urandom_range(lft, rgt));
						cy = 8'($urandom_range(bot, tp));
					end
					send_word(OP_WRITE, 8'(j), cx, cy, 17'($urandom_range(0, POINT_MAX)),
						17'($urandom_range(0, POINT_MAX)), pick_gap(burst), 1'b0, 1'b0);
				end
			end

			nq = (cnt > STORE_DEPTH || n_eff == STORE_DEPTH) ? 6 : $urandom_range(15, 40);
			for (i = 0; i < nq; i++) begin
				if ($urandom_range(0, 9) == 0) begin
					// overwrite any vertex mid-stream
					send_word(OP_WRITE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)), 17'($urandom_range(0, POINT_MAX)),
						17'($urandom_range(0, POINT_MAX)), pick_gap(burst), 1'b0, 1'b0);
				end else begin
					sel = $urandom_range(0, 9);
					if ((sel == 1 || sel == 2) && (kind == 0 || n_eff == 0))
						sel = 3;
					v = (n_eff > 0) ? $urandom_range(0, n_eff - 1) : 0;
					w = (v == 0) ? n_eff - 1 : v - 1;
					if (sel == 0) begin
						qx = 17'($urandom_range(0, POINT_MAX));
						qy = 17'($urandom_range(0, POINT_MAX));
					end else if (sel == 1) begin
						// on a vertex, sometimes half a unit off
						qx = {1'b0, outline_x[v], 8'h00};
						qy = {1'b0, outline_y[v], 8'h00};
						if ($urandom_range(0, 1) == 1)
							qx = qx + 17'(HALF_UNIT);
						if ($urandom_range(0, 1) == 1)
							qy = qy + 17'(HALF_UNIT);
					end else if (sel == 2) begin
						qx = 17'((int'(outline_x[v]) + int'(outline_x[w])) << (FRAC - 1));
						qy = 17'((int'(outline_y[v]) + int'(outline_y[w])) << (FRAC - 1));
					end else begin
						qx = pick_fixed(lft, rgt);
						qy = pick_fixed(bot, tp);
					end
					send_word(OP_QUERY, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)), qx, qy, pick_gap(burst), 1'b0, 1'b0);
				end
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_inside.size() == 0)
			$display("PASS glyph_point_in_polygon_top");
		else
			$display("FAIL glyph_point_in_polygon_top");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+src
src/gpip_pkg.sv
src/gpip_front.sv
src/gpip_queue.sv
src/gpip_back.sv
src/glyph_point_in_polygon_top.sv
tb/sv/glyph_point_in_polygon_top_tb.sv
